/* sv/jvs_pkg.sv */
// Shared types, constants and helpers for the joystick velocity shaper.
// No dependencies; imported by every module of the block.
package jvs_pkg;

    // Width of each stick or trigger sample (signed Q1.(AXIS_BITS-1))
    localparam int AXIS_BITS = 16;
    localparam logic [AXIS_BITS-1:0] AXIS_HALF = {1'b1, {(AXIS_BITS - 1){1'b0}}};

    localparam int GAIN_BITS  = 16;
    localparam int BAND_BITS  = 15;
    localparam int Q15_BITS   = 16;
    localparam int MAG_BITS   = 17;   // |x| in Q1.16, up to 65536
    localparam int SQ_BITS    = 34;
    localparam int CUBE_BITS  = 49;
    localparam int CUBE_Q_BITS = 16;  // rounded cube, Q.15, up to 32768
    localparam int BF_BITS    = 32;
    localparam int GBF_BITS   = 48;
    localparam int PROD_BITS  = 64;
    localparam int RND_BITS   = 27;
    localparam int SPEED_BITS = 24;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [GAIN_BITS-1:0] UNITY = 16'd4096;
    localparam logic [CUBE_BITS-1:0] CUBE_ROUND = 49'h0_0001_0000_0000;
    localparam logic [PROD_BITS-1:0] PROD_ROUND = 64'h0000_0008_0000_0000;
    localparam logic [RND_BITS-1:0] POS_LIMIT = 27'd8388607;
    localparam logic [RND_BITS-1:0] NEG_LIMIT = 27'd8388608;
    localparam logic [SPEED_BITS-1:0] SPEED_POS_MAX = 24'h7F_FFFF;
    localparam logic [SPEED_BITS-1:0] SPEED_NEG_MAG = 24'h80_0000;

    // Register reset values
    localparam logic [GAIN_BITS-1:0] GAIN_RESET  = 16'd2048;
    localparam logic [GAIN_BITS-1:0] BOOST_RESET = 16'd8192;
    localparam logic [GAIN_BITS-1:0] FINE_RESET  = 16'd2048;
    localparam logic [BAND_BITS-1:0] BAND_RESET  = 15'd3277;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_GAIN_FORWARD  = 3'd0,
        REG_GAIN_LATERAL  = 3'd1,
        REG_GAIN_TURN     = 3'd2,
        REG_BOOST_FACTOR  = 3'd3,
        REG_FINE_FACTOR   = 3'd4,
        REG_DEAD_BAND     = 3'd5,
        REG_ENABLE_REQ    = 3'd6,
        REG_STOP_USED     = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        STATUS_DRIVE    = 2'd0,
        STATUS_STOPPED  = 2'd1,
        STATUS_DISABLED = 2'd2
    } drive_status_t;

    typedef struct packed {
        logic [GAIN_BITS-1:0] gain_forward;
        logic [GAIN_BITS-1:0] gain_lateral;
        logic [GAIN_BITS-1:0] gain_turn;
        logic [GAIN_BITS-1:0] boost_factor;
        logic [GAIN_BITS-1:0] fine_factor;
        logic [BAND_BITS-1:0] dead_band;
        logic                 enable_required;
        logic                 stop_button_used;
    } jvs_cfg_t;

    // One classified request: magnitudes in Q1.16 plus sign per axis
    typedef struct packed {
        drive_status_t        status;
        logic                 boost;
        logic                 fine;
        logic                 fwd_neg;
        logic [MAG_BITS-1:0]  fwd_mag;
        logic                 lat_neg;
        logic [MAG_BITS-1:0]  lat_mag;
        logic                 turn_neg;
        logic [MAG_BITS-1:0]  turn_mag;
    } jvs_cmd_t;

    // Bring an axis sample to Q1.15 (floor when narrowing, zero fill when widening)
    function automatic logic signed [Q15_BITS-1:0] axis_to_q15(input logic [AXIS_BITS-1:0] raw);
        logic [AXIS_BITS-1:0]  biased;
        logic [AXIS_BITS+15:0] aligned;
        logic [Q15_BITS-1:0]   b16;
        biased  = raw ^ AXIS_HALF;
        aligned = {biased, 16'b0};
        b16     = aligned[AXIS_BITS+15:AXIS_BITS];
        return signed'(b16 ^ 16'h8000);
    endfunction

endpackage

/* sv/jvs_front.sv */
// Front end: classifies one gamepad sample into a shaping request.
// Depends on jvs_pkg (config struct, request struct, axis conversion).
module jvs_front
    import jvs_pkg::*;
(
    input  logic [AXIS_BITS-1:0] forward_trigger,
    input  logic [AXIS_BITS-1:0] reverse_trigger,
    input  logic [AXIS_BITS-1:0] lateral_axis,
    input  logic [AXIS_BITS-1:0] turn_axis,
    input  logic                 stop_pressed,
    input  logic                 enable_pressed,
    input  logic                 boost_pressed,
    input  logic                 fine_pressed,
    input  jvs_cfg_t             cfg,
    output jvs_cmd_t             cmd
);

    logic signed [Q15_BITS-1:0] fwd_q;
    logic signed [Q15_BITS-1:0] rev_q;
    logic signed [Q15_BITS-1:0] lat_q;
    logic signed [Q15_BITS-1:0] turn_q;
    logic [MAG_BITS-1:0]        diff;
    logic [MAG_BITS-1:0]        fwd_abs;
    logic [MAG_BITS-1:0]        lat_ext;
    logic [MAG_BITS-1:0]        turn_ext;
    logic [MAG_BITS-1:0]        lat_abs_w;
    logic [MAG_BITS-1:0]        turn_abs_w;
    logic [Q15_BITS-1:0]        lat_abs;
    logic [Q15_BITS-1:0]        turn_abs;
    logic                       lat_live;
    logic                       turn_live;
    drive_status_t              status;

    // Convert axes to Q1.15
    assign fwd_q  = axis_to_q15(forward_trigger);
    assign rev_q  = axis_to_q15(reverse_trigger);
    assign lat_q  = axis_to_q15(lateral_axis);
    assign turn_q = axis_to_q15(turn_axis);

    // Forward value: reverse minus forward is already Q1.16
    assign diff    = {rev_q[Q15_BITS-1], rev_q} - {fwd_q[Q15_BITS-1], fwd_q};
    assign fwd_abs = diff[MAG_BITS-1] ? (~diff + 17'd1) : diff;

    // Stick magnitudes in Q1.15, full scale negative counts as 32768
    assign lat_ext    = {lat_q[Q15_BITS-1], lat_q};
    assign turn_ext   = {turn_q[Q15_BITS-1], turn_q};
    assign lat_abs_w  = lat_q[Q15_BITS-1] ? (~lat_ext + 17'd1) : lat_ext;
    assign turn_abs_w = turn_q[Q15_BITS-1] ? (~turn_ext + 17'd1) : turn_ext;
    assign lat_abs    = lat_abs_w[Q15_BITS-1:0];
    assign turn_abs   = turn_abs_w[Q15_BITS-1:0];

    // Drop sticks inside the dead band
    assign lat_live  = lat_abs > {1'b0, cfg.dead_band};
    assign turn_live = turn_abs > {1'b0, cfg.dead_band};

    // Stop wins over a missing enable
    always_comb
    begin
        if (cfg.stop_button_used && stop_pressed)
        begin
            status = STATUS_STOPPED;
        end
        else if (cfg.enable_required && !enable_pressed)
        begin
            status = STATUS_DISABLED;
        end
        else
        begin
            status = STATUS_DRIVE;
        end
    end

    // Build the request; zero magnitudes give zero speeds downstream
    always_comb
    begin
        cmd          = '0;
        cmd.status   = status;
        cmd.boost    = boost_pressed;
        cmd.fine     = fine_pressed;
        if (status == STATUS_DRIVE)
        begin
            cmd.fwd_neg = diff[MAG_BITS-1];
            cmd.fwd_mag = fwd_abs;
            if (lat_live)
            begin
                cmd.lat_neg = lat_q[Q15_BITS-1];
                cmd.lat_mag = {lat_abs, 1'b0};
            end
            if (turn_live)
            begin
                cmd.turn_neg = turn_q[Q15_BITS-1];
                cmd.turn_mag = {turn_abs, 1'b0};
            end
        end
    end

endmodule

/* sv/jvs_queue.sv */
// Short request queue between the front end and the shaping pipeline.
// Depends on jvs_pkg (request struct, queue depth).
module jvs_queue
    import jvs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  jvs_cmd_t push_data,
    input  logic     pop,
    output jvs_cmd_t pop_data,
    output logic     full,
    output logic     empty
);

    jvs_cmd_t                  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic [QUEUE_CNT_BITS-1:0] count_next;

    assign full     = count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Store payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sv/jvs_shaper.sv */
// One axis of the shaping pipeline: cube, gain and factor product, round, saturate.
// Depends on jvs_pkg (widths and rounding constants); stepped by jvs_back.
module jvs_shaper
    import jvs_pkg::*;
(
    input  logic                   clk,
    input  logic                   advance,
    input  logic                   load_neg,
    input  logic [MAG_BITS-1:0]    load_mag,
    input  logic [GAIN_BITS-1:0]   gain,
    input  logic [BF_BITS-1:0]     bf,
    output logic [SPEED_BITS-1:0]  speed
);

    logic [MAG_BITS-1:0]    mag1_reg;
    logic                   neg1_reg;
    logic [SQ_BITS-1:0]     sq2_reg;
    logic [MAG_BITS-1:0]    mag2_reg;
    logic                   neg2_reg;
    logic [CUBE_BITS-1:0]   cube3_reg;
    logic [GBF_BITS-1:0]    gbf3_reg;
    logic                   neg3_reg;
    logic [CUBE_Q_BITS-1:0] c4_reg;
    logic [GBF_BITS-1:0]    gbf4_reg;
    logic                   neg4_reg;
    logic [PROD_BITS-1:0]   p5_reg;
    logic                   neg5_reg;
    logic [SPEED_BITS-1:0]  speed_reg;

    logic [CUBE_BITS-1:0]   cube_sum;
    logic [PROD_BITS-1:0]   prod_sum;
    logic [RND_BITS-1:0]    r;
    logic [SPEED_BITS-1:0]  speed_next;

    // Round cube to Q.15, half away from zero on the magnitude
    assign cube_sum = cube3_reg + CUBE_ROUND;

    // Round product to Q.15, then saturate and apply sign
    assign prod_sum = p5_reg + PROD_ROUND;
    assign r        = prod_sum[62:36];

    always_comb
    begin
        if (neg5_reg)
        begin
            speed_next = (r > NEG_LIMIT) ? SPEED_NEG_MAG : r[SPEED_BITS-1:0];
            speed_next = ~speed_next + 24'd1;
        end
        else
        begin
            speed_next = (r > POS_LIMIT) ? SPEED_POS_MAX : r[SPEED_BITS-1:0];
        end
    end

    // Step all stages together
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mag1_reg  <= load_mag;
            neg1_reg  <= load_neg;
            sq2_reg   <= SQ_BITS'(mag1_reg) * SQ_BITS'(mag1_reg);
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            cube3_reg <= CUBE_BITS'(sq2_reg) * CUBE_BITS'(mag2_reg);
            gbf3_reg  <= GBF_BITS'(gain) * GBF_BITS'(bf);
            neg3_reg  <= neg2_reg;
            c4_reg    <= cube_sum[48:33];
            gbf4_reg  <= gbf3_reg;
            neg4_reg  <= neg3_reg;
            p5_reg    <= PROD_BITS'(c4_reg) * PROD_BITS'(gbf4_reg);
            neg5_reg  <= neg4_reg;
            speed_reg <= speed_next;
        end
    end

    assign speed = speed_reg;

endmodule

/* sv/jvs_back.sv */
// Back end: pops requests, runs three axis shapers in lock step, holds the result.
// Depends on jvs_pkg and jvs_shaper.
module jvs_back
    import jvs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  jvs_cfg_t               cfg,
    input  jvs_cmd_t               head,
    input  logic                   queue_empty,
    output logic                   pop,
    output logic                   command_valid,
    input  logic                   command_ready,
    output logic [SPEED_BITS-1:0]  forward_speed,
    output logic [SPEED_BITS-1:0]  lateral_speed,
    output logic [SPEED_BITS-1:0]  turn_rate,
    output logic [1:0]             drive_status
);

    localparam int STAGES = 6;

    logic [STAGES-1:0]    valid_reg;
    drive_status_t        status_reg [STAGES];
    logic [GAIN_BITS-1:0] boost1_reg;
    logic [GAIN_BITS-1:0] fine1_reg;
    logic [BF_BITS-1:0]   bf2_reg;
    logic                 advance;

    // Whole pipeline moves unless the held result is refused
    assign advance = !valid_reg[STAGES-1] || command_ready;
    assign pop     = advance && !queue_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], !queue_empty};
        end
    end

    // Carry status and factor selection alongside
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg[0] <= head.status;
            for (int i = 1; i < STAGES; i++)
            begin
                status_reg[i] <= status_reg[i-1];
            end
            boost1_reg <= head.boost ? cfg.boost_factor : UNITY;
            fine1_reg  <= head.fine ? cfg.fine_factor : UNITY;
            bf2_reg    <= BF_BITS'(boost1_reg) * BF_BITS'(fine1_reg);
        end
    end

    jvs_shaper u_fwd
    (
        .clk      (clk),
        .advance  (advance),
        .load_neg (head.fwd_neg),
        .load_mag (head.fwd_mag),
        .gain     (cfg.gain_forward),
        .bf       (bf2_reg),
        .speed    (forward_speed)
    );

    jvs_shaper u_lat
    (
        .clk      (clk),
        .advance  (advance),
        .load_neg (head.lat_neg),
        .load_mag (head.lat_mag),
        .gain     (cfg.gain_lateral),
        .bf       (bf2_reg),
        .speed    (lateral_speed)
    );

    jvs_shaper u_turn
    (
        .clk      (clk),
        .advance  (advance),
        .load_neg (head.turn_neg),
        .load_mag (head.turn_mag),
        .gain     (cfg.gain_turn),
        .bf       (bf2_reg),
        .speed    (turn_rate)
    );

    assign command_valid = valid_reg[STAGES-1];
    assign drive_status  = status_reg[STAGES-1];

endmodule

/* sv/joystick_velocity_shaper_core.sv */
// Top level of the joystick velocity shaper: config registers, front end, queue, back end.
// Depends on jvs_pkg, jvs_front, jvs_queue and jvs_back.
//
//   Channel    Handshake                       Payload
//   sample     sample_valid / sample_ready     triggers, sticks, four buttons
//   command    command_valid / command_ready   three speeds, drive_status
//   config     cfg_write (no wait)             cfg_index, cfg_data
//
// One sample is taken per cycle while the queue is not full; when nothing
// stalls, each sample passes through the queue and then steps through the
// six register stages of the shaping pipe.
// The shaping pipe moves as one unit and freezes while a result is refused;
// the 4-entry queue keeps taking samples until it fills.
// Reset clears valid flags, queue pointers and loads register defaults.
module joystick_velocity_shaper_core
    import jvs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                       sample_valid,
    output logic                       sample_ready,
    input  logic [AXIS_BITS-1:0]       forward_trigger,
    input  logic [AXIS_BITS-1:0]       reverse_trigger,
    input  logic [AXIS_BITS-1:0]       lateral_axis,
    input  logic [AXIS_BITS-1:0]       turn_axis,
    input  logic                       stop_pressed,
    input  logic                       enable_pressed,
    input  logic                       boost_pressed,
    input  logic                       fine_pressed,
    output logic                       command_valid,
    input  logic                       command_ready,
    output logic [SPEED_BITS-1:0]      forward_speed,
    output logic [SPEED_BITS-1:0]      lateral_speed,
    output logic [SPEED_BITS-1:0]      turn_rate,
    output logic [1:0]                 drive_status
);

    jvs_cfg_t cfg_reg;
    jvs_cmd_t front_cmd;
    jvs_cmd_t head;
    logic     queue_full;
    logic     queue_empty;
    logic     pop;
    logic     push;

    // Decode register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_forward     <= GAIN_RESET;
            cfg_reg.gain_lateral     <= GAIN_RESET;
            cfg_reg.gain_turn        <= GAIN_RESET;
            cfg_reg.boost_factor     <= BOOST_RESET;
            cfg_reg.fine_factor      <= FINE_RESET;
            cfg_reg.dead_band        <= BAND_RESET;
            cfg_reg.enable_required  <= 1'b0;
            cfg_reg.stop_button_used <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_GAIN_FORWARD: cfg_reg.gain_forward     <= cfg_data;
                REG_GAIN_LATERAL: cfg_reg.gain_lateral     <= cfg_data;
                REG_GAIN_TURN:    cfg_reg.gain_turn        <= cfg_data;
                REG_BOOST_FACTOR: cfg_reg.boost_factor     <= cfg_data;
                REG_FINE_FACTOR:  cfg_reg.fine_factor      <= cfg_data;
                REG_DEAD_BAND:    cfg_reg.dead_band        <= cfg_data[BAND_BITS-1:0];
                REG_ENABLE_REQ:   cfg_reg.enable_required  <= cfg_data[0];
                REG_STOP_USED:    cfg_reg.stop_button_used <= cfg_data[0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Classify incoming samples
    jvs_front u_front
    (
        .forward_trigger (forward_trigger),
        .reverse_trigger (reverse_trigger),
        .lateral_axis    (lateral_axis),
        .turn_axis       (turn_axis),
        .stop_pressed    (stop_pressed),
        .enable_pressed  (enable_pressed),
        .boost_pressed   (boost_pressed),
        .fine_pressed    (fine_pressed),
        .cfg             (cfg_reg),
        .cmd             (front_cmd)
    );

    assign sample_ready = !queue_full;
    assign push         = sample_valid && sample_ready;

    jvs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_cmd),
        .pop       (pop),
        .pop_data  (head),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    jvs_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .head          (head),
        .queue_empty   (queue_empty),
        .pop           (pop),
        .command_valid (command_valid),
        .command_ready (command_ready),
        .forward_speed (forward_speed),
        .lateral_speed (lateral_speed),
        .turn_rate     (turn_rate),
        .drive_status  (drive_status)
    );

endmodule
